>>> sv/tclp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Text command line parser package
// Shared types, codes and helper functions for the command line parser.
// ============================================================================
package tclp_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] EV_HEADER = 3'd0;
    localparam logic [2:0] EV_BYTE   = 3'd1;
    localparam logic [2:0] EV_END    = 3'd2;
    localparam logic [2:0] EV_ACCEPT = 3'd3;
    localparam logic [2:0] EV_ERROR  = 3'd4;

    localparam logic [1:0] KIND_FROM    = 2'd0;
    localparam logic [1:0] KIND_TO      = 2'd1;
    localparam logic [1:0] KIND_FEATURE = 2'd2;
    localparam logic [1:0] KIND_PARAM   = 2'd3;

    localparam logic [3:0] ERR_SHORT       = 4'd0;
    localparam logic [3:0] ERR_TYPE        = 4'd1;
    localparam logic [3:0] ERR_NO_SPACE    = 4'd2;
    localparam logic [3:0] ERR_ESCAPE_EOL  = 4'd3;
    localparam logic [3:0] ERR_BAD_ESCAPE  = 4'd4;
    localparam logic [3:0] ERR_SID_LEN     = 4'd5;
    localparam logic [3:0] ERR_FEATURE_LEN = 4'd6;
    localparam logic [3:0] ERR_UTF8        = 4'd7;
    localparam logic [3:0] ERR_NO_FROM     = 4'd8;
    localparam logic [3:0] ERR_NO_FEATURE  = 4'd9;
    localparam logic [3:0] ERR_NO_TO       = 4'd10;

    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_S         = 8'h73;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    localparam logic [7:0] TYPE_B = 8'h42;
    localparam logic [7:0] TYPE_C = 8'h43;
    localparam logic [7:0] TYPE_D = 8'h44;
    localparam logic [7:0] TYPE_E = 8'h45;
    localparam logic [7:0] TYPE_F = 8'h46;
    localparam logic [7:0] TYPE_H = 8'h48;
    localparam logic [7:0] TYPE_I = 8'h49;
    localparam logic [7:0] TYPE_U = 8'h55;

    localparam logic [2:0] POS_SPACE   = 3'd4;
    localparam logic [2:0] POS_BODY    = 3'd5;
    localparam logic [2:0] SID_LEN     = 3'd4;
    localparam logic [2:0] LEN_SAT     = 3'd5;
    localparam logic [2:0] FEATURE_TOP = 3'd4;

    typedef struct packed {
        logic [2:0]  byte_position;
        logic [7:0]  type_letter;
        logic [23:0] command_letters;
        logic        escape_pending;
        logic        from_done;
        logic        to_done;
        logic        feature_done;
        logic [2:0]  field_length;
        logic [2:0]  feature_mod_five;
        logic [31:0] sid_accumulator;
        logic [1:0]  utf8_pending;
        logic        utf8_bad;
        logic        discarding;
    } state_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [1:0]  field_kind;
        logic [7:0]  out_byte;
        logic [7:0]  type_char;
        logic [23:0] command_code;
        logic [31:0] sid_value;
        logic [3:0]  error_code;
        logic        last_result;
    } result_t;

    typedef struct packed {
        logic [1:0] pending;
        logic       bad;
    } utf8_t;

    function automatic logic needs_from(input logic [7:0] t);
        return (t == TYPE_B) || (t == TYPE_D) || (t == TYPE_E) || (t == TYPE_F);
    endfunction

    function automatic logic needs_to(input logic [7:0] t);
        return (t == TYPE_D) || (t == TYPE_E);
    endfunction

    function automatic logic type_ok(input logic [7:0] t);
        return (t == TYPE_B) || (t == TYPE_C) || (t == TYPE_D) || (t == TYPE_E) ||
               (t == TYPE_F) || (t == TYPE_I) || (t == TYPE_H) || (t == TYPE_U);
    endfunction

    function automatic logic [1:0] cur_kind(input state_t s);
        logic [1:0] k;
        if (needs_from(s.type_letter) && !s.from_done)
            k = KIND_FROM;
        else if (needs_to(s.type_letter) && !s.to_done)
            k = KIND_TO;
        else if ((s.type_letter == TYPE_F) && !s.feature_done)
            k = KIND_FEATURE;
        else
            k = KIND_PARAM;
        return k;
    endfunction

    function automatic result_t make_result(
        input logic [2:0]  ev,
        input logic [1:0]  kind,
        input logic [7:0]  b,
        input logic [7:0]  tc,
        input logic [23:0] cc,
        input logic [31:0] sid,
        input logic [3:0]  err
    );
        result_t r;
        r.event_res    = ev;
        r.field_kind   = kind;
        r.out_byte     = b;
        r.type_char    = tc;
        r.command_code = cc;
        r.sid_value    = sid;
        r.error_code   = err;
        r.last_result  = 1'b0;
        return r;
    endfunction

    function automatic result_t error_result(input logic [3:0] err);
        return make_result(EV_ERROR, KIND_FROM, 8'd0, 8'd0, 24'd0, 32'd0, err);
    endfunction

    // Checks run at the end of a line once the last field is closed.
    function automatic result_t line_end(
        input logic [7:0] t,
        input logic       from_done,
        input logic       to_done,
        input logic       feature_done
    );
        result_t r;
        if (needs_from(t) && !from_done)
            r = error_result(ERR_NO_FROM);
        else if ((t == TYPE_F) && !feature_done)
            r = error_result(ERR_NO_FEATURE);
        else if (needs_to(t) && !to_done)
            r = error_result(ERR_NO_TO);
        else
            r = make_result(EV_ACCEPT, KIND_FROM, 8'd0, 8'd0, 24'd0, 32'd0, ERR_SHORT);
        return r;
    endfunction

    function automatic utf8_t utf8_take(input utf8_t u, input logic [7:0] b);
        utf8_t n;
        n = u;
        if (u.pending != 2'd0) begin
            if ((b >= 8'h80) && (b <= 8'hBF)) begin
                n.pending = u.pending - 2'd1;
            end
            else begin
                n.bad     = 1'b1;
                n.pending = 2'd0;
            end
        end
        else if (b <= 8'h7F) begin
            n = u;
        end
        else if ((b >= 8'hC2) && (b <= 8'hDF)) begin
            n.pending = 2'd1;
        end
        else if ((b >= 8'hE0) && (b <= 8'hEF)) begin
            n.pending = 2'd2;
        end
        else if ((b >= 8'hF0) && (b <= 8'hF4)) begin
            n.pending = 2'd3;
        end
        else begin
            n.bad = 1'b1;
        end
        return n;
    endfunction

endpackage
`default_nettype wire

>>> sv/tclp_line_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Command line byte channel
// Valid/ready channel that carries one byte of a command line per word.
// ============================================================================
interface tclp_line_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink (input valid, input data_byte, input last, output ready);
endinterface
`default_nettype wire

>>> sv/tclp_event_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Parser event channel
// Valid/ready channel that carries one parser event per word.
// ============================================================================
interface tclp_event_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [1:0]  field_kind;
    logic [7:0]  out_byte;
    logic [7:0]  type_char;
    logic [23:0] command_code;
    logic [31:0] sid_value;
    logic [3:0]  error_code;
    logic        last_result;

    modport source (
        output valid, output event_res, output field_kind, output out_byte,
        output type_char, output command_code, output sid_value,
        output error_code, output last_result, input ready
    );
    modport sink (
        input valid, input event_res, input field_kind, input out_byte,
        input type_char, input command_code, input sid_value,
        input error_code, input last_result, output ready
    );
endinterface
`default_nettype wire

>>> sv/tclp_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Command line parser step logic
// Next-state and event logic for one byte of a command line.
// ============================================================================
module tclp_step (
    input  tclp_pkg::state_t  state_cur,
    input  logic [7:0]        data_byte,
    input  logic              last,
    output tclp_pkg::state_t  state_next,
    output tclp_pkg::result_t res_first,
    output tclp_pkg::result_t res_second,
    output logic [1:0]        res_count
);
    import tclp_pkg::*;

    logic [1:0]  kind;
    logic        sid_kind;
    logic        close_bad;
    logic [3:0]  close_code;
    result_t     close_res;
    state_t      close_state;
    result_t     end_after_close;
    result_t     end_open;
    logic [7:0]  escaped;
    logic        escape_ok;
    logic [7:0]  add_val;
    state_t      add_state;
    result_t     add_res;
    utf8_t       utf8_cur;
    utf8_t       utf8_new;
    result_t     r0;
    result_t     r1;
    logic [1:0]  cnt;
    state_t      st;

    assign kind     = cur_kind(state_cur);
    assign sid_kind = (kind == KIND_FROM) || (kind == KIND_TO);

    always_comb
    begin
        close_state = state_cur;
        case (kind)
            KIND_FROM, KIND_TO:
            begin
                close_bad  = state_cur.field_length != SID_LEN;
                close_code = ERR_SID_LEN;
            end
            KIND_FEATURE:
            begin
                close_bad  = state_cur.feature_mod_five != 3'd0;
                close_code = ERR_FEATURE_LEN;
            end
            default:
            begin
                close_bad  = state_cur.utf8_bad || (state_cur.utf8_pending != 2'd0);
                close_code = ERR_UTF8;
            end
        endcase
        if (kind == KIND_FROM)
            close_state.from_done = 1'b1;
        else if (kind == KIND_TO)
            close_state.to_done = 1'b1;
        else if (kind == KIND_FEATURE)
            close_state.feature_done = 1'b1;
        close_state.field_length     = 3'd0;
        close_state.feature_mod_five = 3'd0;
        close_state.sid_accumulator  = 32'd0;
        close_state.utf8_pending     = 2'd0;
        close_state.utf8_bad         = 1'b0;
        close_state.escape_pending   = 1'b0;
        if (close_bad)
            close_res = error_result(close_code);
        else
            close_res = make_result(EV_END, kind, 8'd0, 8'd0, 24'd0,
                                    sid_kind ? state_cur.sid_accumulator : 32'd0,
                                    ERR_SHORT);
    end

    assign end_after_close = line_end(close_state.type_letter, close_state.from_done,
                                      close_state.to_done, close_state.feature_done);
    assign end_open        = line_end(state_cur.type_letter, state_cur.from_done,
                                      state_cur.to_done, state_cur.feature_done);

    always_comb
    begin
        escape_ok = 1'b1;
        case (data_byte)
            CH_S:         escaped = CH_SPACE;
            CH_N:         escaped = CH_LF;
            CH_BACKSLASH: escaped = CH_BACKSLASH;
            default:
            begin
                escaped   = data_byte;
                escape_ok = 1'b0;
            end
        endcase
    end

    assign add_val          = state_cur.escape_pending ? escaped : data_byte;
    assign utf8_cur.pending = state_cur.utf8_pending;
    assign utf8_cur.bad     = state_cur.utf8_bad;
    assign utf8_new         = utf8_take(utf8_cur, add_val);
    assign add_res          = make_result(EV_BYTE, kind, add_val, 8'd0, 24'd0, 32'd0,
                                          ERR_SHORT);

    always_comb
    begin
        add_state = state_cur;
        add_state.escape_pending = 1'b0;
        if (sid_kind && (state_cur.field_length < SID_LEN))
            add_state.sid_accumulator[{state_cur.field_length[1:0], 3'b000} +: 8] =
                state_cur.sid_accumulator[{state_cur.field_length[1:0], 3'b000} +: 8]
                | add_val;
        if (state_cur.field_length < LEN_SAT)
            add_state.field_length = state_cur.field_length + 3'd1;
        if (state_cur.feature_mod_five >= FEATURE_TOP)
            add_state.feature_mod_five = 3'd0;
        else
            add_state.feature_mod_five = state_cur.feature_mod_five + 3'd1;
        if (kind == KIND_PARAM) begin
            add_state.utf8_pending = utf8_new.pending;
            add_state.utf8_bad     = utf8_new.bad;
        end
    end

    always_comb
    begin
        st  = state_cur;
        r0  = '0;
        r1  = '0;
        cnt = 2'd0;
        if (state_cur.discarding) begin
            st = state_cur;
        end
        else if (state_cur.byte_position < POS_SPACE) begin
            if (last) begin
                r0            = error_result(ERR_SHORT);
                cnt           = 2'd1;
                st.discarding = 1'b1;
            end
            else begin
                case (state_cur.byte_position)
                    3'd0:    st.type_letter = data_byte;
                    3'd1:    st.command_letters[23:16] = data_byte;
                    3'd2:    st.command_letters[15:8] = data_byte;
                    default: st.command_letters[7:0] = data_byte;
                endcase
                st.byte_position = state_cur.byte_position + 3'd1;
            end
        end
        else if (state_cur.byte_position == POS_SPACE) begin
            if (!type_ok(state_cur.type_letter)) begin
                r0            = error_result(ERR_TYPE);
                cnt           = 2'd1;
                st.discarding = 1'b1;
            end
            else if (data_byte != CH_SPACE) begin
                r0            = error_result(ERR_NO_SPACE);
                cnt           = 2'd1;
                st.discarding = 1'b1;
            end
            else begin
                r0 = make_result(EV_HEADER, KIND_FROM, 8'd0, state_cur.type_letter,
                                 state_cur.command_letters, 32'd0, ERR_SHORT);
                cnt              = 2'd1;
                st.byte_position = POS_BODY;
                if (last) begin
                    r1  = end_open;
                    cnt = 2'd2;
                end
            end
        end
        else if (last) begin
            if (state_cur.escape_pending) begin
                r0  = error_result(ERR_ESCAPE_EOL);
                cnt = 2'd1;
            end
            else if (state_cur.field_length != 3'd0) begin
                r0  = close_res;
                cnt = 2'd1;
                if (!close_bad) begin
                    r1  = end_after_close;
                    cnt = 2'd2;
                end
            end
            else begin
                r0  = end_open;
                cnt = 2'd1;
            end
        end
        else if (state_cur.escape_pending) begin
            if (escape_ok) begin
                st  = add_state;
                r0  = add_res;
                cnt = 2'd1;
            end
            else begin
                st.escape_pending = 1'b0;
                st.discarding     = 1'b1;
                r0                = error_result(ERR_BAD_ESCAPE);
                cnt               = 2'd1;
            end
        end
        else if (data_byte == CH_BACKSLASH) begin
            st.escape_pending = 1'b1;
        end
        else if (data_byte == CH_SPACE) begin
            r0  = close_res;
            cnt = 2'd1;
            if (close_bad)
                st.discarding = 1'b1;
            else
                st = close_state;
        end
        else begin
            st  = add_state;
            r0  = add_res;
            cnt = 2'd1;
        end

        if (last)
            st = '0;
        if (cnt == 2'd1)
            r0.last_result = 1'b1;
        if (cnt == 2'd2)
            r1.last_result = 1'b1;

        state_next = st;
        res_first  = r0;
        res_second = r1;
        res_count  = cnt;
    end

endmodule
`default_nettype wire

>>> sv/text_command_line_parser_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// Text command line parser
// Splits a text protocol command line into header, field and status words.
// ============================================================================
// The parser takes one line byte per cycle while it is ready, and registers
// the events of each byte taken. Each byte is handled by the combinational
// step logic, and its zero, one or two events go into a four-word event
// queue; the byte channel is ready whenever that queue has room for two
// words, so with the event side taking a word each cycle the rate is one
// byte per cycle. Field bytes of a field that later fails have already been
// sent and must be dropped by the consumer when the error word arrives.
module text_command_line_parser_core (
    input  wire logic clk,
    input  wire logic rst_n,
    tclp_line_if.sink    line,
    tclp_event_if.source events
);
    import tclp_pkg::*;

    state_t                 state_reg;
    state_t                 state_next;
    result_t                res_first;
    result_t                res_second;
    logic [1:0]             res_count;
    result_t                queue_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] wr_ptr_second;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] fill_reg;
    logic [QUEUE_CNT_W-1:0] fill_next;
    logic [1:0]             push_cnt;
    logic                   accept;
    logic                   pop;
    result_t                head;

    tclp_step u_step (
        .state_cur  (state_reg),
        .data_byte  (line.data_byte),
        .last       (line.last),
        .state_next (state_next),
        .res_first  (res_first),
        .res_second (res_second),
        .res_count  (res_count)
    );

    assign line.ready = fill_reg <= QUEUE_CNT_W'(QUEUE_DEPTH - 2);
    assign accept     = line.valid && line.ready;
    assign pop        = events.valid && events.ready;
    assign push_cnt   = accept ? res_count : 2'd0;

    assign wr_ptr_second = wr_ptr_reg + QUEUE_PTR_W'(1);
    assign wr_ptr_next   = wr_ptr_reg + QUEUE_PTR_W'(push_cnt);
    assign rd_ptr_next   = rd_ptr_reg + QUEUE_PTR_W'(pop);
    assign fill_next     = fill_reg + QUEUE_CNT_W'(push_cnt) - QUEUE_CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else begin
            if (accept)
                state_reg <= state_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            queue_reg[wr_ptr_reg] <= res_first;
        if (push_cnt == 2'd2)
            queue_reg[wr_ptr_second] <= res_second;
    end

    assign head                = queue_reg[rd_ptr_reg];
    assign events.valid        = fill_reg != '0;
    assign events.event_res    = head.event_res;
    assign events.field_kind   = head.field_kind;
    assign events.out_byte     = head.out_byte;
    assign events.type_char    = head.type_char;
    assign events.command_code = head.command_code;
    assign events.sid_value    = head.sid_value;
    assign events.error_code   = head.error_code;
    assign events.last_result  = head.last_result;

endmodule
`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Text command line parser testbench
// Sends directed and random command lines a byte at a time, predicts the
// header, field and status words of each byte in a behavioral model of the
// parser, and checks every word that leaves the block in order, with random
// idling and long output stalls on the channels.
// ============================================================================
module tb;
    import tclp_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int LONG_HOLD    = 80;
    localparam int DRAIN_SETTLE = 4;
    localparam int END_SETTLE   = 10;

    logic clk;
    logic rst_n;

    tclp_line_if  line_ch ();
    tclp_event_if event_ch ();

    text_command_line_parser_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .line   (line_ch),
        .events (event_ch)
    );

    result_t        expected_events[$];
    result_t        step_events[$];
    logic [7:0]     line_buf[$];
    int unsigned    fail_count;
    int unsigned    bytes_sent;
    int unsigned    fields_open;
    int unsigned    tx_idle_pct;
    int unsigned    rx_idle_pct;
    int unsigned    hold_request;

    logic [2:0]     ln_pos;
    logic [7:0]     ln_type;
    logic [23:0]    ln_cmd;
    logic           got_from;
    logic           got_to;
    logic           got_feature;
    logic           skip_rest;
    logic           esc_open;
    logic [2:0]     fld_len;
    logic [2:0]     fld_mod5;
    logic [31:0]    fld_sid;
    logic [1:0]     utf8_owed;
    logic           utf8_broken;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic carries_from(input logic [7:0] t);
        return (t == TYPE_B) || (t == TYPE_D) || (t == TYPE_E) || (t == TYPE_F);
    endfunction

    function automatic logic carries_to(input logic [7:0] t);
        return (t == TYPE_D) || (t == TYPE_E);
    endfunction

    function automatic void reset_field();
        esc_open    = 1'b0;
        fld_len     = 3'd0;
        fld_mod5    = 3'd0;
        fld_sid     = 32'd0;
        utf8_owed   = 2'd0;
        utf8_broken = 1'b0;
    endfunction

    function automatic void clear_line_state();
        reset_field();
        ln_pos      = 3'd0;
        ln_type     = 8'd0;
        ln_cmd      = 24'd0;
        got_from    = 1'b0;
        got_to      = 1'b0;
        got_feature = 1'b0;
        skip_rest   = 1'b0;
    endfunction

    function automatic void queue_event(input logic [2:0] ev, input logic [1:0] kind,
                                        input logic [7:0] b, input logic [7:0] tc,
                                        input logic [23:0] cc, input logic [31:0] sid,
                                        input logic [3:0] err);
        result_t r;
        r              = '0;
        r.event_res    = ev;
        r.field_kind   = kind;
        r.out_byte     = b;
        r.type_char    = tc;
        r.command_code = cc;
        r.sid_value    = sid;
        r.error_code   = err;
        step_events    = {step_events, r};
    endfunction

    function automatic void raise_error(input logic [3:0] err);
        skip_rest = 1'b1;
        queue_event(EV_ERROR, KIND_FROM, 8'd0, 8'd0, 24'd0, 32'd0, err);
    endfunction

    function automatic logic [1:0] current_kind();
        if (carries_from(ln_type) && !got_from)
            return KIND_FROM;
        if (carries_to(ln_type) && !got_to)
            return KIND_TO;
        if ((ln_type == TYPE_F) && !got_feature)
            return KIND_FEATURE;
        return KIND_PARAM;
    endfunction

    function automatic void store_char(input logic [7:0] b);
        logic [1:0] kind;
        kind = current_kind();
        if (((kind == KIND_FROM) || (kind == KIND_TO)) && (fld_len < SID_LEN))
            fld_sid[8 * fld_len +: 8] = b;
        if (fld_len < LEN_SAT)
            fld_len = fld_len + 3'd1;
        fld_mod5 = (fld_mod5 >= FEATURE_TOP) ? 3'd0 : fld_mod5 + 3'd1;
        if (kind == KIND_PARAM)
        begin
            if (utf8_owed != 2'd0)
            begin
                if ((b >= 8'h80) && (b <= 8'hBF))
                    utf8_owed = utf8_owed - 2'd1;
                else
                begin
                    utf8_broken = 1'b1;
                    utf8_owed   = 2'd0;
                end
            end
            else if ((b >= 8'hC2) && (b <= 8'hDF))
                utf8_owed = 2'd1;
            else if ((b >= 8'hE0) && (b <= 8'hEF))
                utf8_owed = 2'd2;
            else if ((b >= 8'hF0) && (b <= 8'hF4))
                utf8_owed = 2'd3;
            else if (b >= 8'h80)
                utf8_broken = 1'b1;
        end
        queue_event(EV_BYTE, kind, b, 8'd0, 24'd0, 32'd0, ERR_SHORT);
    endfunction

    function automatic void close_field();
        logic [1:0]  kind;
        logic [31:0] sid;
        kind = current_kind();
        sid  = 32'd0;
        if ((kind == KIND_FROM) || (kind == KIND_TO))
        begin
            if (fld_len != SID_LEN)
            begin
                raise_error(ERR_SID_LEN);
                return;
            end
            sid = fld_sid;
            if (kind == KIND_FROM)
                got_from = 1'b1;
            else
                got_to = 1'b1;
        end
        else if (kind == KIND_FEATURE)
        begin
            if (fld_mod5 != 3'd0)
            begin
                raise_error(ERR_FEATURE_LEN);
                return;
            end
            got_feature = 1'b1;
        end
        else if (utf8_broken || (utf8_owed != 2'd0))
        begin
            raise_error(ERR_UTF8);
            return;
        end
        reset_field();
        queue_event(EV_END, kind, 8'd0, 8'd0, 24'd0, sid, ERR_SHORT);
    endfunction

    function automatic void end_of_line();
        if (esc_open)
        begin
            raise_error(ERR_ESCAPE_EOL);
            return;
        end
        if (fld_len != 3'd0)
        begin
            close_field();
            if (skip_rest)
                return;
        end
        if (carries_from(ln_type) && !got_from)
            raise_error(ERR_NO_FROM);
        else if ((ln_type == TYPE_F) && !got_feature)
            raise_error(ERR_NO_FEATURE);
        else if (carries_to(ln_type) && !got_to)
            raise_error(ERR_NO_TO);
        else
            queue_event(EV_ACCEPT, KIND_FROM, 8'd0, 8'd0, 24'd0, 32'd0, ERR_SHORT);
    endfunction

    function automatic void predict_line_byte(input logic [7:0] b, input logic lst);
        logic    type_good;
        result_t tail;
        step_events.delete();
        if (skip_rest)
        begin
            if (lst)
                clear_line_state();
            return;
        end
        if (ln_pos < POS_SPACE)
        begin
            if (lst)
                raise_error(ERR_SHORT);
            else
            begin
                if (ln_pos == 3'd0)
                    ln_type = b;
                else
                    ln_cmd[8 * (3 - int'(ln_pos)) +: 8] = b;
                ln_pos = ln_pos + 3'd1;
            end
        end
        else if (ln_pos == POS_SPACE)
        begin
            case (ln_type)
                TYPE_B, TYPE_C, TYPE_D, TYPE_E, TYPE_F, TYPE_H, TYPE_I, TYPE_U:
                    type_good = 1'b1;
                default:
                    type_good = 1'b0;
            endcase
            if (!type_good)
                raise_error(ERR_TYPE);
            else if (b != CH_SPACE)
                raise_error(ERR_NO_SPACE);
            else
            begin
                queue_event(EV_HEADER, KIND_FROM, 8'd0, ln_type, ln_cmd, 32'd0, ERR_SHORT);
                ln_pos = POS_BODY;
                if (lst)
                    end_of_line();
            end
        end
        else if (lst)
            end_of_line();
        else if (esc_open)
        begin
            esc_open = 1'b0;
            if (b == CH_S)
                store_char(CH_SPACE);
            else if (b == CH_N)
                store_char(CH_LF);
            else if (b == CH_BACKSLASH)
                store_char(CH_BACKSLASH);
            else
                raise_error(ERR_BAD_ESCAPE);
        end
        else if (b == CH_BACKSLASH)
            esc_open = 1'b1;
        else if (b == CH_SPACE)
            close_field();
        else
            store_char(b);
        if (lst)
            clear_line_state();
        if (step_events.size() != 0)
        begin
            tail = step_events.pop_back();
            tail.last_result = 1'b1;
            step_events = {step_events, tail};
        end
        expected_events = {expected_events, step_events};
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin : event_check
        result_t want;
        if (rst_n && event_ch.valid && event_ch.ready)
        begin
            if (expected_events.size() == 0)
            begin
                $error("event word with nothing expected: event_res 0x%0h",
                       event_ch.event_res);
                fail_count++;
            end
            else
            begin
                want = expected_events.pop_front();
                compare_field("event_res", 32'(want.event_res), 32'(event_ch.event_res));
                compare_field("field_kind", 32'(want.field_kind), 32'(event_ch.field_kind));
                compare_field("out_byte", 32'(want.out_byte), 32'(event_ch.out_byte));
                compare_field("type_char", 32'(want.type_char), 32'(event_ch.type_char));
                compare_field("command_code", 32'(want.command_code),
                              32'(event_ch.command_code));
                compare_field("sid_value", want.sid_value, event_ch.sid_value);
                compare_field("error_code", 32'(want.error_code), 32'(event_ch.error_code));
                compare_field("last_result", 32'(want.last_result),
                              32'(event_ch.last_result));
            end
        end
    end

    initial
    begin : event_sink
        event_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                event_ch.ready <= 1'b0;
                repeat (hold_request) @(negedge clk);
                hold_request = 0;
            end
            else if ((rx_idle_pct != 0) && ($urandom_range(0, 99) < rx_idle_pct))
            begin
                event_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4) - 1) @(negedge clk);
            end
            else
                event_ch.ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((line_ch.valid && line_ch.ready) || (event_ch.valid && event_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    // Called and returning just after a falling edge; valid stays up between words unless an idle gap is drawn.
    task automatic send_byte(input logic [7:0] b, input logic lst);
        if ((tx_idle_pct != 0) && ($urandom_range(0, 99) < tx_idle_pct))
        begin
            line_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        line_ch.valid     <= 1'b1;
        line_ch.data_byte <= b;
        line_ch.last      <= lst;
        @(posedge clk);
        while (!line_ch.ready)
            @(posedge clk);
        predict_line_byte(b, lst);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_line();
        foreach (line_buf[i])
            send_byte(line_buf[i], i == line_buf.size() - 1);
    endtask

    task automatic wait_drained();
        line_ch.valid <= 1'b0;
        while (expected_events.size() != 0)
            @(negedge clk);
        repeat (DRAIN_SETTLE) @(negedge clk);
    endtask

    function automatic void append_byte(input logic [7:0] b);
        line_buf = {line_buf, b};
    endfunction

    function automatic void push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            append_byte(s[i]);
    endfunction

    function automatic logic [7:0] any_text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if ((b == CH_SPACE) || (b == CH_BACKSLASH))
            b = 8'h7E;
        return b;
    endfunction

    function automatic void push_escape();
        append_byte(CH_BACKSLASH);
        case ($urandom_range(0, 2))
            0:       append_byte(CH_S);
            1:       append_byte(CH_N);
            default: append_byte(CH_BACKSLASH);
        endcase
    endfunction

    function automatic void push_plain_char();
        if ($urandom_range(0, 9) < 3)
            push_escape();
        else
            append_byte(any_text_byte());
    endfunction

    function automatic void push_param_char();
        int unsigned r;
        logic [7:0]  b;
        r = $urandom_range(0, 59);
        if (r < 4)
            push_escape();
        else if (r < 24)
        begin
            b = 8'($urandom_range(8'h21, 8'h7E));
            append_byte((b == CH_BACKSLASH) ? 8'h61 : b);
        end
        else if (r < 27)
            append_byte(8'($urandom_range(0, 31)));
        else if (r < 36)
        begin
            append_byte(8'($urandom_range(8'hC2, 8'hDF)));
            append_byte(8'($urandom_range(8'h80, 8'hBF)));
        end
        else if (r < 46)
        begin
            append_byte(8'($urandom_range(8'hE0, 8'hEF)));
            repeat (2) append_byte(8'($urandom_range(8'h80, 8'hBF)));
        end
        else if (r < 58)
        begin
            append_byte(8'($urandom_range(8'hF0, 8'hF4)));
            repeat (3) append_byte(8'($urandom_range(8'h80, 8'hBF)));
        end
        else if (r == 58)
            append_byte(8'($urandom_range(8'h80, 8'hFF)));
        else
        begin
            b = 8'($urandom_range(0, 255));
            if ((b == CH_S) || (b == CH_N) || (b == CH_BACKSLASH))
                b = 8'h71;
            append_byte(CH_BACKSLASH);
            append_byte(b);
        end
    endfunction

    function automatic void push_field_gap();
        if (fields_open != 0)
        begin
            append_byte(CH_SPACE);
            if ($urandom_range(0, 14) == 0)
                append_byte(CH_SPACE);
        end
        fields_open++;
    endfunction

    function automatic void push_sid();
        push_field_gap();
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : 4)
            push_plain_char();
    endfunction

    function automatic void build_random_line();
        logic [7:0]  t;
        int unsigned cut;
        line_buf.delete();
        fields_open = 0;
        if ($urandom_range(0, 15) == 0)
            t = 8'($urandom_range(0, 255));
        else
            case ($urandom_range(0, 7))
                0:       t = TYPE_B;
                1:       t = TYPE_C;
                2:       t = TYPE_D;
                3:       t = TYPE_E;
                4:       t = TYPE_F;
                5:       t = TYPE_H;
                6:       t = TYPE_I;
                default: t = TYPE_U;
            endcase
        append_byte(t);
        repeat (3)
            append_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(8'h41, 8'h5A)));
        append_byte(($urandom_range(0, 24) == 0) ? any_text_byte() : CH_SPACE);
        if (carries_from(t) && ($urandom_range(0, 7) != 0))
            push_sid();
        if (carries_to(t) && ($urandom_range(0, 7) != 0))
            push_sid();
        if ((t == TYPE_F) && ($urandom_range(0, 7) != 0))
        begin
            push_field_gap();
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(1, 9)
                                                : 5 * $urandom_range(0, 2))
                push_plain_char();
        end
        repeat ($urandom_range(0, 4))
        begin
            push_field_gap();
            repeat ($urandom_range(0, 6))
                push_param_char();
        end
        if ($urandom_range(0, 7) == 0)
            append_byte(CH_SPACE);
        if ($urandom_range(0, 19) == 0)
            append_byte(CH_BACKSLASH);
        if ($urandom_range(0, 11) == 0)
        begin
            cut = $urandom_range(0, line_buf.size());
            while (line_buf.size() > cut)
                void'(line_buf.pop_back());
        end
        append_byte(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : CH_LF);
    endfunction

    task automatic test_directed_lines();
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        line_buf = '{8'h00};
        send_line();
        line_buf.delete();
        push_str("ZABC ");
        send_line();
        line_buf.delete();
        push_str("HXYZ ");
        send_line();
        line_buf = '{TYPE_C, 8'h00, 8'hFF, 8'h71, CH_SPACE, 8'hFF, 8'hFF};
        send_line();
        line_buf.delete();
        push_str("BINF ");
        append_byte(CH_LF);
        send_line();
        wait_drained();
    endtask

    task automatic test_random_lines();
        while (bytes_sent < 400)
        begin
            case ($urandom_range(0, 2))
                0:       tx_idle_pct = 0;
                1:       tx_idle_pct = 15;
                default: tx_idle_pct = 40;
            endcase
            case ($urandom_range(0, 2))
                0:       rx_idle_pct = 0;
                1:       rx_idle_pct = 15;
                default: rx_idle_pct = 40;
            endcase
            build_random_line();
            send_line();
        end
        wait_drained();
    endtask

    // The sink stops taking words while the line keeps coming, so the event
    // queue fills and the byte channel has to back off.
    task automatic test_output_stall();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_request = LONG_HOLD;
        line_buf.delete();
        push_str("CMSG ");
        repeat (6)
        begin
            repeat (5) push_param_char();
            append_byte(CH_SPACE);
        end
        append_byte(CH_LF);
        send_line();
        hold_request = LONG_HOLD;
        repeat (3)
        begin
            build_random_line();
            send_line();
        end
        wait_drained();
    endtask

    task automatic test_paced_lines();
        tx_idle_pct = 10;
        rx_idle_pct = 10;
        repeat (6)
        begin
            build_random_line();
            send_line();
            wait_drained();
        end
    endtask

    task automatic test_back_to_back();
        int unsigned target;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        target = bytes_sent + 120;
        while (bytes_sent < target)
        begin
            build_random_line();
            send_line();
        end
        wait_drained();
    endtask

    initial
    begin : stimulus
        rst_n             = 1'b0;
        line_ch.valid     = 1'b0;
        line_ch.data_byte = 8'd0;
        line_ch.last      = 1'b0;
        fail_count        = 0;
        bytes_sent        = 0;
        fields_open       = 0;
        tx_idle_pct       = 0;
        rx_idle_pct       = 0;
        hold_request      = 0;
        clear_line_state();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);
        test_directed_lines();
        test_random_lines();
        test_output_stall();
        test_paced_lines();
        test_back_to_back();
        repeat (END_SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
